// ===== src/npcm_pkg.sv =====
// Shared types and constants for the nearest palette color mapper.
package npcm_pkg;

  localparam int DEFAULT_DEPTH = 256;

  localparam int COLOR_W = 8;
  localparam int INDEX_W = 8;
  localparam int DIST_W  = 18;
  localparam int SIZE_W  = 9;
  localparam int SQ_W    = 2 * COLOR_W;
  localparam int RGB_W   = 3 * COLOR_W;

  localparam logic [SIZE_W-1:0] SIZE_RESET = 9'd256;

  localparam logic FUNC_WRITE = 1'b0;
  localparam logic FUNC_MAP   = 1'b1;

  typedef struct packed {
    logic               func;
    logic [INDEX_W-1:0] entry_index;
    logic [COLOR_W-1:0] red;
    logic [COLOR_W-1:0] green;
    logic [COLOR_W-1:0] blue;
    logic               end_of_image;
  } pixel_t;

  typedef struct packed {
    logic [COLOR_W-1:0] near_red;
    logic [COLOR_W-1:0] near_green;
    logic [COLOR_W-1:0] near_blue;
    logic [INDEX_W-1:0] palette_index;
    logic [DIST_W-1:0]  distance;
    logic               last_out;
  } result_t;

  typedef struct packed {
    logic               valid;
    pixel_t             item;
    logic [DIST_W-1:0]  best_dist;
    logic [INDEX_W-1:0] best_index;
    logic [RGB_W-1:0]   best_color;
  } beat_t;

  function automatic logic [SQ_W-1:0] sq_diff(input logic [COLOR_W-1:0] a,
                                              input logic [COLOR_W-1:0] b);
    logic [COLOR_W-1:0] d;
    d = (a > b) ? (a - b) : (b - a);
    return SQ_W'(d) * SQ_W'(d);
  endfunction

endpackage

// ===== src/npcm_cell.sv =====
// One palette cell: holds one entry, squares the differences, then keeps the running best.
module npcm_cell #(
  parameter int CELL_INDEX = 0
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       advance,
  input  logic [npcm_pkg::SIZE_W-1:0] palette_size,
  input  npcm_pkg::beat_t            beat_in,
  output npcm_pkg::beat_t            beat_out
);

  localparam bit                          FIRST     = (CELL_INDEX == 0);
  localparam bit                          CAN_WRITE = (CELL_INDEX < 256);
  localparam logic [npcm_pkg::INDEX_W-1:0] MY_INDEX = npcm_pkg::INDEX_W'(CELL_INDEX);

  logic [npcm_pkg::RGB_W-1:0]  entry;
  npcm_pkg::beat_t             mid;
  logic [npcm_pkg::RGB_W-1:0]  mid_color;
  logic [npcm_pkg::SQ_W-1:0]   sq_r;
  logic [npcm_pkg::SQ_W-1:0]   sq_g;
  logic [npcm_pkg::SQ_W-1:0]   sq_b;
  npcm_pkg::beat_t             beat_out_next;
  logic [npcm_pkg::DIST_W-1:0] sum_sq;
  logic                        active;
  logic                        take;
  logic                        write_hit;

  assign write_hit = CAN_WRITE && beat_in.valid &&
                     (beat_in.item.func == npcm_pkg::FUNC_WRITE) &&
                     (beat_in.item.entry_index == MY_INDEX);

  always_ff @(posedge clk) begin
    if (advance && write_hit) begin
      entry <= {beat_in.item.red, beat_in.item.green, beat_in.item.blue};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mid.valid <= 1'b0;
    end else if (advance) begin
      mid       <= beat_in;
      mid_color <= entry;
      sq_r      <= npcm_pkg::sq_diff(entry[23:16], beat_in.item.red);
      sq_g      <= npcm_pkg::sq_diff(entry[15:8], beat_in.item.green);
      sq_b      <= npcm_pkg::sq_diff(entry[7:0], beat_in.item.blue);
    end
  end

  assign sum_sq = npcm_pkg::DIST_W'(sq_r) + npcm_pkg::DIST_W'(sq_g) +
                  npcm_pkg::DIST_W'(sq_b);
  assign active = FIRST || (32'(palette_size) > CELL_INDEX);
  assign take   = (mid.item.func == npcm_pkg::FUNC_MAP) && active &&
                  (FIRST || (sum_sq < mid.best_dist));

  always_comb begin
    beat_out_next = mid;
    if (take) begin
      beat_out_next.best_dist  = sum_sq;
      beat_out_next.best_index = MY_INDEX;
      beat_out_next.best_color = mid_color;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      beat_out.valid <= 1'b0;
    end else if (advance) begin
      beat_out <= beat_out_next;
    end
  end

endmodule

// ===== src/nearest_palette_color_mapper.sv =====
// Top level: chain of palette cells with an output register and the size register.
// Palette entries and pixels enter on the same channel and travel down a chain of
// PALETTE_DEPTH cells, one cell per palette entry, two register stages per cell. A
// new beat is taken every cycle while the result side keeps up; a pixel's result
// passes every cell of the chain and then the output register. An entry write
// travels the same chain and lands in its cell in order with the pixels around
// it, so a pixel sees exactly the writes taken before it. When the result register
// is full and stalled, the whole chain holds.
module nearest_palette_color_mapper #(
  parameter int PALETTE_DEPTH = npcm_pkg::DEFAULT_DEPTH
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        pixel_valid,
  output logic                        pixel_stall,
  input  npcm_pkg::pixel_t            pixel,
  output logic                        result_valid,
  input  logic                        result_stall,
  output npcm_pkg::result_t           result,
  input  logic                        cfg_write,
  input  logic [npcm_pkg::SIZE_W-1:0] cfg_data
);

  logic                        advance;
  logic [npcm_pkg::SIZE_W-1:0] palette_size;
  npcm_pkg::beat_t             chain [PALETTE_DEPTH+1];
  npcm_pkg::beat_t             tail;

  assign advance     = !result_valid || !result_stall;
  assign pixel_stall = !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      palette_size <= npcm_pkg::SIZE_RESET;
    end else if (cfg_write) begin
      palette_size <= cfg_data;
    end
  end

  always_comb begin
    chain[0]            = '0;
    chain[0].valid      = pixel_valid;
    chain[0].item       = pixel;
  end

  for (genvar k = 0; k < PALETTE_DEPTH; k++) begin : g_cell
    npcm_cell #(
      .CELL_INDEX (k)
    ) u_cell (
      .clk          (clk),
      .rst          (rst),
      .advance      (advance),
      .palette_size (palette_size),
      .beat_in      (chain[k]),
      .beat_out     (chain[k+1])
    );
  end

  assign tail = chain[PALETTE_DEPTH];

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance) begin
      result_valid <= tail.valid && (tail.item.func == npcm_pkg::FUNC_MAP);
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      result.near_red      <= tail.best_color[23:16];
      result.near_green    <= tail.best_color[15:8];
      result.near_blue     <= tail.best_color[7:0];
      result.palette_index <= tail.best_index;
      result.distance      <= tail.best_dist;
      result.last_out      <= tail.item.end_of_image;
    end
  end

endmodule
